>>> rtl/gbnrx_pkg.sv
// ----------------------------------------------------------------------------
// gbnrx_pkg
// Shared types, register indexes and checksum helpers for the go-back-n
// receiver with checksum.
// ----------------------------------------------------------------------------
package gbnrx_pkg;

	// register indexes on the configuration port (byte address = 4 * index)
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_CODE_DATA = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CODE_ACK  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CODE_FIN  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_START_SEQ = 2'd3;

	// reset values of the registers
	localparam logic [7:0] CODE_DATA_RST = 8'd0;
	localparam logic [7:0] CODE_ACK_RST  = 8'd1;
	localparam logic [7:0] CODE_FIN_RST  = 8'd2;
	localparam logic [7:0] START_SEQ_RST = 8'd0;

	// input item function codes
	localparam logic FUNC_WORD    = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	// connection state
	typedef enum logic [1:0] {
		CONN_ESTABLISHED  = 2'd0,
		CONN_FIN_RECEIVED = 2'd1,
		CONN_CLOSED       = 2'd2
	} conn_state_t;

	typedef struct packed {
		logic [7:0] code_data;
		logic [7:0] code_ack;
		logic [7:0] code_fin;
		logic [7:0] start_seq;
	} cfg_t;

	typedef struct packed {
		logic        func;
		logic [15:0] word;
		logic        first;
		logic        last;
		logic [15:0] rx_checksum;
	} item_t;

	typedef struct packed {
		logic        ack_valid;
		logic [7:0]  ack_seq;
		logic [15:0] ack_checksum;
		logic        deliver;
		logic        fin_received;
		logic        checksum_bad;
	} result_t;

	// fold a 32-bit ones-complement sum twice and invert it
	function automatic logic [15:0] fold_invert(input logic [31:0] acc);
		logic [16:0] part;
		logic [15:0] folded;
		part   = {1'b0, acc[31:16]} + {1'b0, acc[15:0]};
		folded = part[15:0] + {15'd0, part[16]};
		return ~folded;
	endfunction

endpackage

>>> rtl/gbnrx_apb_regs.sv
// ----------------------------------------------------------------------------
// gbnrx_apb_regs
// APB register file holding the packet type codes and the restart sequence
// number.
// ----------------------------------------------------------------------------
module gbnrx_apb_regs
	import gbnrx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	cfg_t                 cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_data <= CODE_DATA_RST;
			cfg_q.code_ack  <= CODE_ACK_RST;
			cfg_q.code_fin  <= CODE_FIN_RST;
			cfg_q.start_seq <= START_SEQ_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_CODE_DATA: cfg_q.code_data <= pwdata[7:0];
				REG_CODE_ACK:  cfg_q.code_ack  <= pwdata[7:0];
				REG_CODE_FIN:  cfg_q.code_fin  <= pwdata[7:0];
				REG_START_SEQ: cfg_q.start_seq <= pwdata[7:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (idx)
			REG_CODE_DATA: prdata = {24'd0, cfg_q.code_data};
			REG_CODE_ACK:  prdata = {24'd0, cfg_q.code_ack};
			REG_CODE_FIN:  prdata = {24'd0, cfg_q.code_fin};
			REG_START_SEQ: prdata = {24'd0, cfg_q.start_seq};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

>>> rtl/gbnrx_engine.sv
// ----------------------------------------------------------------------------
// gbnrx_engine
// Connection state, running checksum and per-packet verdict. Applies one
// registered item per cycle with fire high; forms the result for a last word.
// ----------------------------------------------------------------------------
module gbnrx_engine
	import gbnrx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    fire,
	output logic    res_valid,
	output result_t res
);

	conn_state_t conn_q, conn_next;
	logic [7:0]  exp_q, exp_next;
	logic [31:0] sum_q, sum_next;
	logic [7:0]  type_q, seq_q;
	logic [7:0]  type_cur, seq_cur;
	logic        bad, good_est, is_fin, is_data, in_order;
	logic [7:0]  exp_plus, seq_plus;

	// running sum and header of the packet including the current word
	always_comb begin
		if (item.first) begin
			sum_next = {16'd0, item.word};
			type_cur = item.word[15:8];
			seq_cur  = item.word[7:0];
		end else begin
			sum_next = sum_q + {16'd0, item.word};
			type_cur = type_q;
			seq_cur  = seq_q;
		end
	end

	// packet verdict
	assign bad      = fold_invert(sum_next) != item.rx_checksum;
	assign good_est = !bad && (conn_q == CONN_ESTABLISHED);
	assign is_fin   = good_est && (type_cur == cfg.code_fin);
	assign is_data  = good_est && !is_fin && (type_cur == cfg.code_data);
	assign in_order = seq_cur == exp_q;
	assign exp_plus = exp_q + 8'd1;
	assign seq_plus = seq_cur + 8'd1;

	// next connection state and expected sequence number
	always_comb begin
		conn_next = conn_q;
		exp_next  = exp_q;
		if (item.func == FUNC_RESTART) begin
			conn_next = CONN_ESTABLISHED;
			exp_next  = cfg.start_seq;
		end else if (item.last) begin
			if (is_fin) begin
				conn_next = CONN_FIN_RECEIVED;
				exp_next  = seq_plus;
			end else if (is_data && in_order) begin
				exp_next = exp_plus;
			end
		end
	end

	// result of a last word
	always_comb begin
		res_valid        = (item.func == FUNC_WORD) && item.last;
		res              = '0;
		res.checksum_bad = bad;
		res.fin_received = is_fin;
		if (is_data) begin
			res.ack_valid    = 1'b1;
			res.deliver      = in_order;
			res.ack_seq      = exp_next;
			res.ack_checksum = ~{cfg.code_ack, exp_next};
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_q <= CONN_ESTABLISHED;
			exp_q  <= 8'd0;
			sum_q  <= 32'd0;
			type_q <= 8'd0;
			seq_q  <= 8'd0;
		end else if (fire) begin
			conn_q <= conn_next;
			exp_q  <= exp_next;
			if (item.func == FUNC_RESTART) begin
				sum_q <= 32'd0;
			end else begin
				sum_q  <= sum_next;
				type_q <= type_cur;
				seq_q  <= seq_cur;
			end
		end
	end

endmodule

>>> rtl/gbn_receiver_with_checksum.sv
// ----------------------------------------------------------------------------
// gbn_receiver_with_checksum
// Go-back-n receiver that checks the ones-complement checksum of each packet
// and decides on acknowledge, delivery and fin.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one 16-bit packet word per transaction, s_tlast on the last
//   word, which also carries the received checksum. s_tuser[0] = 1 restarts
//   the connection as established with the start_seq register value.
//   Master stream: one result transaction per last word, none otherwise.
//   APB port: four 8-bit registers (code_data, code_ack, code_fin, start_seq)
//   at byte addresses 0, 4, 8, 12; write them only while the block is idle.
// Pipeline: a word is registered at input, then processed into the output
//   register, from which the result of a last word is offered.
// Throughput: one word per cycle when not stalled; the add, fold and compare
//   of the checksum and the sequence check fit in the single processing stage.
// Reset: connection established, expected sequence zero, sum cleared,
//   registers back to their reset codes, both streams empty.
// Stall: when m_tready is low with a result pending, a word in the input
//   register is held there and s_tready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gbn_receiver_with_checksum
	import gbnrx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // word[15:0], rx_checksum[31:16]
	input  logic [1:0]  s_tuser,   // func[0], first[1]
	input  logic        s_tlast,   // last
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // ack_valid[0], ack_seq[8:1], ack_checksum[24:9],
	                               // deliver[25], fin_received[26], checksum_bad[27]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_free, s1_move, s_fire;
	logic    res_valid;
	result_t res;
	result_t res_s2;
	logic    valid_s2;

	gbnrx_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake control
	assign out_free = !valid_s2 || m_tready;
	assign s1_move  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_fire   = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.func        <= s_tuser[0];
			item_s1.first       <= s_tuser[1];
			item_s1.last        <= s_tlast;
			item_s1.word        <= s_tdata[15:0];
			item_s1.rx_checksum <= s_tdata[31:16];
		end
	end

	gbnrx_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item_s1),
		.fire      (s1_move),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= s1_move && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.checksum_bad, res_s2.fin_received, res_s2.deliver,
		res_s2.ack_checksum, res_s2.ack_seq, res_s2.ack_valid};

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the go-back-n receiver with checksum. Packets and
// stray words are sent with random gaps, the result stream stalls on its own
// pattern, and every result is compared field by field against a running
// model of the connection state, expected sequence and packet checksum.
// ----------------------------------------------------------------------------
module testbench;
	import gbnrx_pkg::*;

	// clock, reset and block ports
	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // word[15:0], rx_checksum[31:16]
	logic [1:0]  s_tuser  = '0;   // func[0], first[1]
	logic        s_tlast  = 1'b0; // last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // ack_valid[0], ack_seq[8:1], ack_checksum[24:9],
	                              // deliver[25], fin_received[26], checksum_bad[27]
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// receiver model state and register copy
	cfg_t        rx_cfg;
	conn_state_t rx_conn;
	logic [7:0]  rx_expect;
	logic [31:0] rx_sum;
	logic [7:0]  rx_type;
	logic [7:0]  rx_seq;
	result_t     pending_verdicts[$];

	// traffic shaping and bookkeeping
	int          mismatch_count = 0;
	int          words_sent     = 0;
	int          burst_left     = 0;
	bit          gaps_on        = 1'b1;
	int          hold_off       = 0;
	int          stall_mode     = 0;
	int          mode_left      = 0;
	logic [7:0]  stall_phase    = '0;
	result_t     got, want;

	gbn_receiver_with_checksum uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

	// ones-complement fold of a 32-bit sum, inverted
	function automatic logic [15:0] ones_fold_inv(input logic [31:0] s);
		logic [31:0] a;
		a = {16'd0, s[31:16]} + {16'd0, s[15:0]};
		a = a + (a >> 16);
		return ~a[15:0];
	endfunction

	function automatic logic [15:0] packet_ck(input logic [31:0] acc, input bit good);
		logic [15:0] ck;
		ck = ones_fold_inv(acc);
		if (!good)
			ck = ck ^ 16'($urandom_range(1, 65535));
		return ck;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] g, input logic [15:0] w);
		if (g !== w)
			report_mismatch($sformatf("%s got %0h want %0h", name, g, w));
	endtask

	// update the connection model with one accepted word and queue the verdict of a last word
	task automatic judge_word(input item_t it);
		result_t r;
		if (it.func == FUNC_RESTART) begin
			rx_conn   = CONN_ESTABLISHED;
			rx_expect = rx_cfg.start_seq;
			rx_sum    = '0;
			return;
		end
		if (it.first) begin
			rx_sum  = {16'd0, it.word};
			rx_type = it.word[15:8];
			rx_seq  = it.word[7:0];
		end else begin
			rx_sum = rx_sum + {16'd0, it.word};
		end
		if (!it.last)
			return;
		r = '0;
		r.checksum_bad = (ones_fold_inv(rx_sum) != it.rx_checksum);
		if (rx_conn == CONN_ESTABLISHED && !r.checksum_bad) begin
			// fin wins when the fin and data codes are equal
			if (rx_type == rx_cfg.code_fin) begin
				rx_conn        = CONN_FIN_RECEIVED;
				rx_expect      = rx_seq + 8'd1;
				r.fin_received = 1'b1;
			end else if (rx_type == rx_cfg.code_data) begin
				if (rx_seq == rx_expect) begin
					rx_expect = rx_expect + 8'd1;
					r.deliver = 1'b1;
				end
				r.ack_valid    = 1'b1;
				r.ack_seq      = rx_expect;
				r.ack_checksum = ones_fold_inv({16'd0, rx_cfg.code_ack, rx_expect});
			end
		end
		pending_verdicts.push_back(r);
	endtask

	// result stream check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.ack_valid    = m_tdata[0];
			got.ack_seq      = m_tdata[8:1];
			got.ack_checksum = m_tdata[24:9];
			got.deliver      = m_tdata[25];
			got.fin_received = m_tdata[26];
			got.checksum_bad = m_tdata[27];
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = pending_verdicts.pop_front();
				check_field("ack_valid", 16'(got.ack_valid), 16'(want.ack_valid));
				check_field("ack_seq", 16'(got.ack_seq), 16'(want.ack_seq));
				check_field("ack_checksum", got.ack_checksum, want.ack_checksum);
				check_field("deliver", 16'(got.deliver), 16'(want.deliver));
				check_field("fin_received", 16'(got.fin_received), 16'(want.fin_received));
				check_field("checksum_bad", 16'(got.checksum_bad), 16'(want.checksum_bad));
			end
		end
	end

	// result stream ready: long hold-off on request, else a changing stall pattern
	always @(posedge clk) begin
		if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off--;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(16, 120);
			end
			mode_left--;
			stall_phase++;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= (stall_phase[2:0] < 3'd5);
				default: m_tready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	// one input transaction; valid stays high into the next burst item
	task automatic send_item(input item_t it);
		if (gaps_on && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {it.rx_checksum, it.word};
		s_tuser  <= {it.first, it.func};
		s_tlast  <= it.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		judge_word(it);
		words_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic send_word(input logic [15:0] w, input bit first_w, input bit last_w,
			input logic [15:0] ck);
		item_t it;
		it.func        = FUNC_WORD;
		it.word        = w;
		it.first       = first_w;
		it.last        = last_w;
		it.rx_checksum = ck;
		send_item(it);
	endtask

	// restart with random content in the ignored fields
	task automatic send_restart;
		item_t it;
		it.func        = FUNC_RESTART;
		it.word        = 16'($urandom_range(0, 65535));
		it.first       = 1'($urandom_range(0, 1));
		it.last        = 1'($urandom_range(0, 1));
		it.rx_checksum = 16'($urandom_range(0, 65535));
		send_item(it);
	endtask

	// header word plus payload words, checksum on the last word
	task automatic send_packet(input logic [7:0] ptype, input logic [7:0] pseq,
			input int n_payload, input bit good);
		logic [31:0] acc;
		logic [15:0] w;
		int          k;
		acc = {16'd0, ptype, pseq};
		send_word({ptype, pseq}, 1'b1, n_payload == 0,
			(n_payload == 0) ? packet_ck(acc, good) : 16'($urandom_range(0, 65535)));
		for (k = 1; k <= n_payload; k++) begin
			case ($urandom_range(0, 9))
				0: w = 16'hffff;
				1: w = 16'h0000;
				default: w = 16'($urandom_range(0, 65535));
			endcase
			acc = acc + {16'd0, w};
			send_word(w, 1'b0, k == n_payload,
				(k == n_payload) ? packet_ck(acc, good) : 16'($urandom_range(0, 65535)));
		end
	endtask

	// drop valid and let the block drain before touching registers
	task automatic wait_idle;
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// apb write followed by a read back of the same register
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_CODE_DATA: rx_cfg.code_data = val;
			REG_CODE_ACK:  rx_cfg.code_ack  = val;
			REG_CODE_FIN:  rx_cfg.code_fin  = val;
			default:       rx_cfg.start_seq = val;
		endcase
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[7:0] !== val)
			report_mismatch($sformatf("register %0d read %0h want %0h", idx, prdata[7:0], val));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all_regs(input logic [7:0] d, input logic [7:0] a,
			input logic [7:0] f, input logic [7:0] s);
		wait_idle;
		write_reg(REG_CODE_DATA, d);
		write_reg(REG_CODE_ACK, a);
		write_reg(REG_CODE_FIN, f);
		write_reg(REG_START_SEQ, s);
	endtask

	// reset codes: orphan words, in-order, duplicate, bad, foreign types, fin
	task automatic test_directed_cases;
		// words before any first fall into the reset header (data, seq 0)
		send_word(16'h1234, 1'b0, 1'b0, 16'hffff);
		send_word(16'h0001, 1'b0, 1'b1, ones_fold_inv(32'h1235));
		send_packet(CODE_DATA_RST, 8'h01, 0, 1'b1);
		send_packet(CODE_DATA_RST, 8'h01, 2, 1'b1);
		send_packet(CODE_DATA_RST, 8'h02, 3, 1'b0);
		send_packet(8'h7f, 8'h02, 1, 1'b1);
		send_packet(CODE_ACK_RST, 8'h02, 0, 1'b1);
		// restart with every ignored field set
		send_item('{func: FUNC_RESTART, word: 16'hffff, first: 1'b1, last: 1'b1,
			rx_checksum: 16'hffff});
		// all-ones and all-zero payload words
		send_word(16'h0000, 1'b1, 1'b0, 16'h0000);
		send_word(16'hffff, 1'b0, 1'b0, 16'h0000);
		send_word(16'h0000, 1'b0, 1'b0, 16'hffff);
		send_word(16'hffff, 1'b0, 1'b1, ones_fold_inv(32'h0001fffe));
		// fin, then packets while not established
		send_packet(CODE_FIN_RST, 8'h40, 1, 1'b1);
		send_packet(CODE_DATA_RST, 8'h41, 0, 1'b1);
		send_packet(CODE_DATA_RST, 8'h41, 1, 1'b0);
		send_restart;
		// one-word packets with extreme checksums
		send_word(16'hffff, 1'b1, 1'b1, 16'h0000);
		send_word(16'hffff, 1'b1, 1'b1, 16'hffff);
		send_packet(CODE_DATA_RST, 8'h00, 0, 1'b1);
	endtask

	// fin and data sharing one code, sequence wrap, all-ones ack code
	task automatic test_shared_codes;
		write_all_regs(8'h55, 8'hff, 8'h55, 8'hff);
		send_restart;
		send_packet(8'h55, 8'hff, 1, 1'b1);
		send_restart;
		wait_idle;
		write_reg(REG_CODE_FIN, 8'h00);
		send_packet(8'h55, 8'hff, 0, 1'b1);
		send_packet(8'h55, 8'h00, 2, 1'b1);
		send_packet(8'h00, 8'h10, 0, 1'b1);
		send_restart;
	endtask

	// result side holds off while one-word packets keep coming
	task automatic test_input_stall;
		int i;
		gaps_on  = 1'b0;
		hold_off = 300;
		for (i = 0; i < 60; i++)
			send_packet(rx_cfg.code_data, rx_expect, 0, 1'b1);
		gaps_on = 1'b1;
	endtask

	// long packet of all-ones words carries the running sum well past 16 bits
	task automatic test_long_packet;
		logic [31:0] acc;
		int          k;
		gaps_on = 1'b0;
		send_restart;
		acc = {16'd0, rx_cfg.code_data, rx_expect};
		send_word({rx_cfg.code_data, rx_expect}, 1'b1, 1'b0, 16'h0000);
		for (k = 0; k < 100; k++) begin
			acc = acc + 32'h0000ffff;
			send_word(16'hffff, 1'b0, 1'b0, 16'h0000);
		end
		acc = acc + 32'h0000ffff;
		send_word(16'hffff, 1'b0, 1'b1, ones_fold_inv(acc));
		gaps_on = 1'b1;
	endtask

	// mostly well-formed packets under several register settings
	task automatic test_random_traffic;
		int          phase;
		int          phase_start;
		int          r;
		logic [7:0]  ptype;
		logic [7:0]  pseq;
		logic [7:0]  v;
		for (phase = 0; phase < 5; phase++) begin
			v = 8'($urandom_range(0, 255));
			case (phase)
				0: write_all_regs(8'h00, 8'hff, 8'hff, 8'hff);
				1: write_all_regs(8'hff, 8'h00, 8'h00, 8'h00);
				2: write_all_regs(v, 8'($urandom_range(0, 255)), v, 8'($urandom_range(0, 255)));
				default: write_all_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			send_restart;
			phase_start = words_sent;
			while (words_sent - phase_start < 320) begin
				r = $urandom_range(0, 99);
				if ((rx_conn != CONN_ESTABLISHED && $urandom_range(0, 1)) || r < 5) begin
					send_restart;
				end else if (r < 12) begin
					// stray word with random flags
					send_word(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
				end else begin
					r = $urandom_range(0, 99);
					if (r < 65)      ptype = rx_cfg.code_data;
					else if (r < 75) ptype = rx_cfg.code_fin;
					else if (r < 85) ptype = rx_cfg.code_ack;
					else             ptype = 8'($urandom_range(0, 255));
					r = $urandom_range(0, 99);
					if (r < 60)      pseq = rx_expect;
					else if (r < 75) pseq = rx_expect - 8'd1;
					else if (r < 85) pseq = rx_expect + 8'd1;
					else             pseq = 8'($urandom_range(0, 255));
					send_packet(ptype, pseq,
						($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 24),
						$urandom_range(0, 99) < 85);
				end
			end
		end
	endtask

	// test sequence
	initial begin
		rx_cfg.code_data = CODE_DATA_RST;
		rx_cfg.code_ack  = CODE_ACK_RST;
		rx_cfg.code_fin  = CODE_FIN_RST;
		rx_cfg.start_seq = START_SEQ_RST;
		rx_conn   = CONN_ESTABLISHED;
		rx_expect = '0;
		rx_sum    = '0;
		rx_type   = '0;
		rx_seq    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases;
		test_shared_codes;
		test_input_stall;
		test_long_packet;
		test_random_traffic;
		wait_idle;
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
